### design/rau_pkg.sv
package rau_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FIELD_W  = 32;
    localparam int DEN_W    = 31;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_REDUCE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INC    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEC    = 3'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
    } t_rau_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] res_num;
        logic [DEN_W-1:0]          res_den;
        logic                      a_less_b;
        logic                      a_equal_b;
        logic                      a_nonzero;
        logic [STATUS_W-1:0]       status;
    } t_rau_out;

endpackage

### design/rau_if.sv
interface rau_in_if import rau_pkg::*; ();
    logic    valid;
    logic    ready;
    t_rau_in payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
    logic     valid;
    logic     ready;
    t_rau_out payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### design/rau_reduce.sv
module rau_reduce import rau_pkg::*; #(
    parameter int MAG_WIDTH = 2 * VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MAG_WIDTH-1:0] i_num,
    input  logic [MAG_WIDTH-1:0] i_den,
    output logic                 o_done,
    output logic [MAG_WIDTH-1:0] o_num,
    output logic [MAG_WIDTH-1:0] o_den
);

    localparam int MW = MAG_WIDTH;
    localparam int KW = $clog2(MW + 1);
    localparam int CW = $clog2(MW);
    localparam logic [CW-1:0] CNT_LAST = CW'(MW - 1);

    localparam logic [1:0] RS_IDLE = 2'd0;
    localparam logic [1:0] RS_GCD  = 2'd1;
    localparam logic [1:0] RS_DIVN = 2'd2;
    localparam logic [1:0] RS_DIVD = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [MW-1:0] r_u, n_u, r_v, n_v;
    logic [KW-1:0] r_k, n_k;
    logic [MW-1:0] r_g, n_g;
    logic [MW-1:0] r_num, n_num, r_den, n_den;
    logic [MW-1:0] r_rem, n_rem, r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [MW-1:0] r_qn, n_qn, r_qd, n_qd;
    logic          r_done, n_done;

    logic [MW:0]   gdiff, gneg;
    logic [MW:0]   div_trial;
    logic [MW+1:0] div_diff;
    logic          div_ge;
    logic [MW-1:0] step_rem, step_quo;

    assign gdiff     = {1'b0, r_u} - {1'b0, r_v};
    assign gneg      = {1'b0, r_v} - {1'b0, r_u};
    assign div_trial = {r_rem, r_quo[MW-1]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, r_g};
    assign div_ge    = !div_diff[MW+1];
    assign step_rem  = div_ge ? div_diff[MW-1:0] : div_trial[MW-1:0];
    assign step_quo  = {r_quo[MW-2:0], div_ge};

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_v     = r_v;
        n_k     = r_k;
        n_g     = r_g;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_qn    = r_qn;
        n_qd    = r_qd;
        n_done  = 1'b0;
        unique case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    n_num   = i_num;
                    n_den   = i_den;
                    n_u     = i_num;
                    n_v     = i_den;
                    n_k     = '0;
                    n_state = RS_GCD;
                end
            end
            RS_GCD: begin
                priority if (r_u == '0) begin
                    n_g     = r_v << r_k;
                    n_rem   = '0;
                    n_quo   = r_num;
                    n_cnt   = CNT_LAST;
                    n_state = RS_DIVN;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (!gdiff[MW]) begin
                    n_u = gdiff[MW-1:0] >> 1;
                end else begin
                    n_v = gneg[MW-1:0] >> 1;
                end
            end
            RS_DIVN: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_qn    = step_quo;
                    n_rem   = '0;
                    n_quo   = r_den;
                    n_cnt   = CNT_LAST;
                    n_state = RS_DIVD;
                end
            end
            default: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_qd    = step_quo;
                    n_done  = 1'b1;
                    n_state = RS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_k   <= n_k;
        r_g   <= n_g;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_qn  <= n_qn;
        r_qd  <= n_qd;
    end

    assign o_done = r_done;
    assign o_num  = r_qn;
    assign o_den  = r_qd;

endmodule

### design/rational_arith_unit.sv
// Exact rational arithmetic: each transfer carries a kind and two operands a and b, both
// reduced to lowest terms with a positive denominator, then a is reduced, added to b, or
// stepped by one (other kinds give no value), and the reduced result, or a range status
// if it does not fit, is returned with a < b, a == b and a != 0 flags. One item is in
// flight at a time; the input is ready only between items. A zero denominator skips the
// arithmetic and returns only a zero-denominator status. Otherwise the item passes through
// two or three reductions on a bit-serial unit (a binary gcd, then two restoring divisions)
// and three products on one shared multiplier, three reductions only for add. The result
// is held in an output register until its transfer.
module rational_arith_unit import rau_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);

    localparam int W  = VALUE_WIDTH;
    localparam int MW = 2 * W;
    localparam int NW = W + 1;
    localparam int PW = 2 * NW;
    localparam int SW = PW + 1;
    localparam int TW = W + 2;
    localparam logic [MW-1:0] LIM = MW'(64'd1 << (W - 1));

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RED_A  = 4'd1;
    localparam logic [3:0] S_RED_B  = 4'd2;
    localparam logic [3:0] S_MUL_AB = 4'd3;
    localparam logic [3:0] S_MUL_BA = 4'd4;
    localparam logic [3:0] S_MUL_DD = 4'd5;
    localparam logic [3:0] S_EVAL   = 4'd6;
    localparam logic [3:0] S_RED_R  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    function automatic logic [MW-1:0] mag_of(input logic signed [W-1:0] x);
        logic [W:0] e;
        e = {x[W-1], x};
        if (e[W]) begin
            e = ~e + 1'b1;
        end
        return MW'(e);
    endfunction

    logic [3:0]              r_state, n_state;
    logic [KIND_W-1:0]       r_kind, n_kind;
    logic signed [W-1:0]     r_bn, n_bn, r_bd, n_bd;
    logic signed [NW-1:0]    r_a_n, n_a_n, r_b_n, n_b_n;
    logic [W-1:0]            r_a_d, n_a_d, r_b_d, n_b_d;
    logic signed [PW-1:0]    r_p1, n_p1, r_p2, n_p2, r_p3, n_p3;
    logic                    r_start, n_start;
    logic [MW-1:0]           r_red_num, n_red_num, r_red_den, n_red_den;
    logic                    r_red_neg, n_red_neg;
    logic                    r_rneg, n_rneg;
    logic [MW-1:0]           r_rmag, n_rmag, r_rden, n_rden;
    logic                    r_have, n_have;
    logic                    r_lt, n_lt, r_eq, n_eq, r_nz, n_nz;
    t_rau_out                r_out, n_out;

    logic signed [W-1:0]     in_an, in_ad, in_bn, in_bd;
    logic                    red_done;
    logic [MW-1:0]           red_qn, red_qd;
    logic signed [NW-1:0]    red_qn_s;
    logic signed [NW-1:0]    mul_x, mul_y;
    logic signed [PW-1:0]    mul_p;
    logic signed [SW-1:0]    sum;
    logic [SW-1:0]           sum_abs;
    logic signed [TW-1:0]    step;
    logic [TW-1:0]           step_abs;
    logic [NW-1:0]           a_abs;
    logic                    fits;
    logic signed [W-1:0]     num_w;

    rau_reduce #(
        .MAG_WIDTH (MW)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (r_red_num),
        .i_den   (r_red_den),
        .o_done  (red_done),
        .o_num   (red_qn),
        .o_den   (red_qd)
    );

    assign in_an = i_in.payload.a_num[W-1:0];
    assign in_ad = i_in.payload.a_den[W-1:0];
    assign in_bn = i_in.payload.b_num[W-1:0];
    assign in_bd = i_in.payload.b_den[W-1:0];

    assign red_qn_s = red_qn[NW-1:0];

    always_comb begin
        unique case (r_state)
            S_MUL_AB: begin
                mul_x = r_a_n;
                mul_y = {1'b0, r_b_d};
            end
            S_MUL_BA: begin
                mul_x = r_b_n;
                mul_y = {1'b0, r_a_d};
            end
            default: begin
                mul_x = {1'b0, r_a_d};
                mul_y = {1'b0, r_b_d};
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    assign sum      = SW'(r_p1) + SW'(r_p2);
    assign sum_abs  = sum[SW-1] ? SW'(-sum) : SW'(sum);
    assign step     = (r_kind == KIND_INC) ? TW'(r_a_n) + TW'({1'b0, r_a_d})
                                           : TW'(r_a_n) - TW'({1'b0, r_a_d});
    assign step_abs = step[TW-1] ? TW'(-step) : TW'(step);
    assign a_abs    = r_a_n[NW-1] ? NW'(-r_a_n) : NW'(r_a_n);

    assign fits  = (r_rden < LIM) && (r_rneg ? (r_rmag <= LIM) : (r_rmag < LIM));
    assign num_w = r_rneg ? -r_rmag[W-1:0] : r_rmag[W-1:0];

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_bn      = r_bn;
        n_bd      = r_bd;
        n_a_n     = r_a_n;
        n_b_n     = r_b_n;
        n_a_d     = r_a_d;
        n_b_d     = r_b_d;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_p3      = r_p3;
        n_start   = 1'b0;
        n_red_num = r_red_num;
        n_red_den = r_red_den;
        n_red_neg = r_red_neg;
        n_rneg    = r_rneg;
        n_rmag    = r_rmag;
        n_rden    = r_rden;
        n_have    = r_have;
        n_lt      = r_lt;
        n_eq      = r_eq;
        n_nz      = r_nz;
        n_out     = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind = i_in.payload.kind;
                    n_bn   = in_bn;
                    n_bd   = in_bd;
                    if (in_ad == '0 || in_bd == '0) begin
                        n_out        = '0;
                        n_out.status = ST_ZERO_DEN;
                        n_state      = S_OUT;
                    end else begin
                        n_red_num = mag_of(in_an);
                        n_red_den = mag_of(in_ad);
                        n_red_neg = in_an[W-1] ^ in_ad[W-1];
                        n_start   = 1'b1;
                        n_state   = S_RED_A;
                    end
                end
            end
            S_RED_A: begin
                if (red_done) begin
                    n_a_n     = r_red_neg ? -red_qn_s : red_qn_s;
                    n_a_d     = red_qd[W-1:0];
                    n_red_num = mag_of(r_bn);
                    n_red_den = mag_of(r_bd);
                    n_red_neg = r_bn[W-1] ^ r_bd[W-1];
                    n_start   = 1'b1;
                    n_state   = S_RED_B;
                end
            end
            S_RED_B: begin
                if (red_done) begin
                    n_b_n   = r_red_neg ? -red_qn_s : red_qn_s;
                    n_b_d   = red_qd[W-1:0];
                    n_state = S_MUL_AB;
                end
            end
            S_MUL_AB: begin
                n_p1    = mul_p;
                n_state = S_MUL_BA;
            end
            S_MUL_BA: begin
                n_p2    = mul_p;
                n_state = S_MUL_DD;
            end
            S_MUL_DD: begin
                n_p3    = mul_p;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_lt   = r_p1 < r_p2;
                n_eq   = (r_a_n == r_b_n) && (r_a_d == r_b_d);
                n_nz   = r_a_n != '0;
                n_have = 1'b1;
                n_rden = MW'(r_a_d);
                unique case (r_kind)
                    KIND_REDUCE: begin
                        n_rneg  = r_a_n[NW-1];
                        n_rmag  = MW'(a_abs);
                        n_state = S_FIN;
                    end
                    KIND_ADD: begin
                        n_red_num = MW'(sum_abs);
                        n_red_den = MW'(r_p3);
                        n_red_neg = sum[SW-1];
                        n_start   = 1'b1;
                        n_state   = S_RED_R;
                    end
                    KIND_INC, KIND_DEC: begin
                        n_rneg  = step[TW-1];
                        n_rmag  = MW'(step_abs);
                        n_state = S_FIN;
                    end
                    default: begin
                        n_have  = 1'b0;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_RED_R: begin
                if (red_done) begin
                    n_rneg  = r_red_neg;
                    n_rmag  = red_qn;
                    n_rden  = red_qd;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_out.res_num   = '0;
                n_out.res_den   = '0;
                n_out.status    = ST_OK;
                n_out.a_less_b  = r_lt;
                n_out.a_equal_b = r_eq;
                n_out.a_nonzero = r_nz;
                if (r_have) begin
                    if (fits) begin
                        n_out.res_num = FIELD_W'(num_w);
                        n_out.res_den = DEN_W'(r_rden[W-1:0]);
                    end else begin
                        n_out.status = ST_RANGE;
                    end
                end
                n_state = S_OUT;
            end
            default: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_a_n     <= n_a_n;
        r_b_n     <= n_b_n;
        r_a_d     <= n_a_d;
        r_b_d     <= n_b_d;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_p3      <= n_p3;
        r_red_num <= n_red_num;
        r_red_den <= n_red_den;
        r_red_neg <= n_red_neg;
        r_rneg    <= n_rneg;
        r_rmag    <= n_rmag;
        r_rden    <= n_rden;
        r_have    <= n_have;
        r_lt      <= n_lt;
        r_eq      <= n_eq;
        r_nz      <= n_nz;
        r_out     <= n_out;
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = (r_state == S_OUT);
    assign o_out.payload = r_out;

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;

    localparam logic [KIND_W-1:0] KIND_CMP   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LAST  = 3'd7;

    localparam logic signed [FIELD_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] VMAX = 32'sh7FFF_FFFF;

    localparam int RANDOM_ITEMS = 380;
    localparam int CALM_ITEMS   = 50;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 1000;

    class rational_scoreboard;
        typedef struct {
            longint num;
            longint den;
        } t_frac;

        t_rau_out pending_results[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function longint part_value(logic [FIELD_W-1:0] f);
            return $signed(f[VW-1:0]);
        endfunction

        static function t_frac lowest_terms(longint n, longint d);
            longint unsigned mn, md, x, y, t;
            t_frac r;
            mn = (n < 0) ? -n : n;
            md = (d < 0) ? -d : d;
            x = mn;
            y = md;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            mn = mn / x;
            md = md / x;
            r.num = ((n < 0) != (d < 0)) ? -longint'(mn) : longint'(mn);
            r.den = longint'(md);
            return r;
        endfunction

        function t_rau_out rational_result(t_rau_in p);
            longint   an, ad, bn, bd, lim;
            t_frac    a, b, r;
            bit       has_value;
            t_rau_out e;
            e = '0;
            e.status = ST_OK;
            an = part_value(p.a_num);
            ad = part_value(p.a_den);
            bn = part_value(p.b_num);
            bd = part_value(p.b_den);
            if (ad == 0 || bd == 0) begin
                e.status = ST_ZERO_DEN;
                return e;
            end
            a = lowest_terms(an, ad);
            b = lowest_terms(bn, bd);
            has_value = 1'b1;
            case (p.kind)
                KIND_REDUCE: r = a;
                KIND_ADD:    r = lowest_terms(a.num * b.den + b.num * a.den, a.den * b.den);
                KIND_INC:    r = lowest_terms(a.num + a.den, a.den);
                KIND_DEC:    r = lowest_terms(a.num - a.den, a.den);
                default:     has_value = 1'b0;
            endcase
            lim = longint'(1) <<< (VW - 1);
            if (has_value) begin
                if (r.num >= -lim && r.num < lim && r.den < lim) begin
                    e.res_num = FIELD_W'(r.num);
                    e.res_den = DEN_W'(r.den);
                end else begin
                    e.status = ST_RANGE;
                end
            end
            e.a_less_b  = (a.num * b.den < b.num * a.den);
            e.a_equal_b = (a.num == b.num && a.den == b.den);
            e.a_nonzero = (a.num != 0);
            return e;
        endfunction

        function void note_operands(t_rau_in p);
            pending_results.push_back(rational_result(p));
        endfunction

        function void check_result(t_rau_out got);
            t_rau_out e;
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: num %0d den %0d lt %0b eq %0b nz %0b st %0d",
                             got.res_num, got.res_den, got.a_less_b, got.a_equal_b,
                             got.a_nonzero, got.status);
                mismatches++;
                return;
            end
            e = pending_results.pop_front();
            if (got.res_num !== e.res_num || got.res_den !== e.res_den
                    || got.a_less_b !== e.a_less_b || got.a_equal_b !== e.a_equal_b
                    || got.a_nonzero !== e.a_nonzero || got.status !== e.status) begin
                if (mismatches < 10) begin
                    $display("mismatch expected: num %0d den %0d lt %0b eq %0b nz %0b st %0d",
                             e.res_num, e.res_den, e.a_less_b, e.a_equal_b,
                             e.a_nonzero, e.status);
                    $display("         actual:   num %0d den %0d lt %0b eq %0b nz %0b st %0d",
                             got.res_num, got.res_den, got.a_less_b, got.a_equal_b,
                             got.a_nonzero, got.status);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rau_in_if  in_if ();
    rau_out_if out_if ();

    rational_scoreboard results = new();

    int stall_cycles = 0;
    int send_idle_pct;
    int recv_stall_pct;
    bit calm_tail;

    rational_arith_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            results.check_result(out_if.payload);
        if (i_rst_n && in_if.valid && in_if.ready)
            results.note_operands(in_if.payload);
        if (i_rst_n && ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    function automatic logic signed [FIELD_W-1:0] random_part();
        logic signed [FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 40) - 20;
            6: begin
                case ($urandom_range(0, 4))
                    0:       v = VMIN;
                    1:       v = VMAX;
                    2:       v = -1;
                    3:       v = 0;
                    default: v = 1;
                endcase
            end
            7: begin
                v = 1 << $urandom_range(0, 30);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom_range(1, 5000) * ($urandom_range(0, 2000) - 1000);
        endcase
        return v;
    endfunction

    function automatic t_rau_in random_item();
        t_rau_in     p;
        int unsigned pick;
        int unsigned scale;
        pick = $urandom_range(0, 11);
        p.kind  = (pick > KIND_LAST) ? KIND_ADD : pick[KIND_W-1:0];
        p.a_num = random_part();
        p.a_den = random_part();
        p.b_num = random_part();
        p.b_den = random_part();
        if (p.a_den == 0)
            p.a_den = 1;
        if (p.b_den == 0)
            p.b_den = 1;
        // tie b to a so that equal rationals show up often
        case ($urandom_range(0, 9))
            0: begin
                p.b_num = p.a_num;
                p.b_den = p.a_den;
            end
            1: begin
                scale   = $urandom_range(2, 9);
                p.b_num = p.a_num * scale;
                p.b_den = p.a_den * scale;
                if ($urandom_range(0, 1)) begin
                    p.b_num = -p.b_num;
                    p.b_den = -p.b_den;
                end
            end
            default: ;
        endcase
        if ($urandom_range(0, 39) == 0)
            p.a_den = '0;
        if ($urandom_range(0, 39) == 0)
            p.b_den = '0;
        return p;
    endfunction

    task automatic send_item(t_rau_in p);
        if (!calm_tail && $urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_if.payload = p;
        in_if.valid   = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_fields(logic [KIND_W-1:0] k, logic signed [FIELD_W-1:0] an,
                               logic signed [FIELD_W-1:0] ad, logic signed [FIELD_W-1:0] bn,
                               logic signed [FIELD_W-1:0] bd);
        t_rau_in p;
        p.kind  = k;
        p.a_num = an;
        p.a_den = ad;
        p.b_num = bn;
        p.b_den = bd;
        send_item(p);
    endtask

    initial begin
        int stall_left;
        int cycle_count;
        out_if.ready   = 1'b0;
        stall_left     = 0;
        cycle_count    = 0;
        recv_stall_pct = 0;
        forever begin
            @(negedge i_clk);
            if (cycle_count % 300 == 0)
                recv_stall_pct = pick_pct();
            cycle_count++;
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if (!calm_tail && $urandom_range(0, 99) < recv_stall_pct) begin
                out_if.ready = 1'b0;
                stall_left   = $urandom_range(1, 9) - 1;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        send_idle_pct = 20;
        calm_tail     = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_fields(KIND_REDUCE, 6, -4, 1, 1);
        send_fields(KIND_REDUCE, 0, -7, 0, 3);
        send_fields(KIND_REDUCE, VMIN, -1, 1, 2);
        send_fields(KIND_REDUCE, 1, VMIN, -1, VMAX);
        send_fields(KIND_REDUCE, VMIN, VMIN, VMAX, VMAX);
        send_fields(KIND_REDUCE, VMAX, VMIN, VMIN, VMAX);
        send_fields(KIND_ADD, 1, 2, 1, 3);
        send_fields(KIND_ADD, VMAX, 1, VMAX, 1);
        send_fields(KIND_ADD, 1, VMAX, 1, VMAX - 1);
        send_fields(KIND_ADD, -1, 2, 1, 2);
        send_fields(KIND_ADD, VMIN, 1, VMIN, 1);
        send_fields(KIND_INC, VMAX, 1, 0, 1);
        send_fields(KIND_INC, -3, 4, 5, -6);
        send_fields(KIND_DEC, VMIN, 1, 0, -1);
        send_fields(KIND_DEC, 5, -3, 7, 7);
        send_fields(KIND_CMP, 2, 4, -1, -2);
        send_fields(KIND_CMP, VMIN, 1, VMAX, 1);
        send_fields(KIND_SPARE, 3, 5, 2, 5);
        send_fields(KIND_LAST, -1, -1, 1, 1);
        send_fields(KIND_ADD, 3, 0, 1, 2);
        send_fields(KIND_REDUCE, 4, 6, 9, 0);
        send_fields(KIND_CMP, 0, 0, 0, 0);
        send_fields(KIND_REDUCE, 0, 5, 0, -3);
        send_fields(KIND_ADD, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_fields(KIND_DEC, -1, -1, -1, -1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                send_idle_pct = pick_pct();
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm_tail = 1'b1;
            // hold off until the block has drained every pending result
            if (n == RANDOM_ITEMS / 2) begin
                in_if.valid = 1'b0;
                while (results.pending_results.size() != 0)
                    @(negedge i_clk);
            end
            send_item(random_item());
        end
        in_if.valid = 1'b0;

        while (results.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (results.mismatches == 0 && results.pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
